// ----- design/rprp_pkg.sv -----
package rprp_pkg;

   // Input item: command plus rectangle size
   typedef struct packed {
      logic        cmd;
      logic [11:0] rect_width;
      logic [10:0] rect_height;
   } req_item_type;

   // Result item: placement corner, canvas size and status
   typedef struct packed {
      logic [10:0] place_x;
      logic [9:0]  place_y;
      logic [10:0] canvas_height;
      logic [11:0] canvas_width;
      logic        status;
   } rsp_item_type;

   // Command codes
   localparam logic CMD_CLEAR = 1'b0;
   localparam logic CMD_PLACE = 1'b1;

   // Status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NO_ROOM = 1'b1;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_INIT_HEIGHT = 2'd0,
      CSR_INIT_WIDTH  = 2'd1,
      CSR_GROWTH      = 2'd2
   } csr_index_type;

   // Register reset values
   localparam int INIT_HEIGHT_RST = 320;
   localparam int INIT_WIDTH_RST  = 544;
   localparam int GROWTH_RST      = 20;

   // Divide by 100 as multiply and shift, exact for values below 43699
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int DIV100_MUL_W = 13;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_DECIDE,
      ST_GROW_DIV,
      ST_GROW_MUL,
      ST_WRITE,
      ST_RESP
   } state_type;

endpackage

// ----- design/row_profile_rect_packer_core.sv -----
// Place item: accepted in idle, then a profile scan per try (one scan more than growth
// steps), a divide and a multiply per growth step, covered rows written if placed, result.
// Clear item: accepted, all MAX_ROWS rows swept to zero, result; a stalled result holds it.
// One item at a time; the row-at-a-time scan, write and sweep of the row memory set the rate.
// Reset: synchronous, active high; a clearing pass over all MAX_ROWS rows follows with
// req_stall high, configuration writes are still taken.
module row_profile_rect_packer_core #(
   parameter int MAX_ROWS = 1024,
   parameter int MAX_COLS = 2048
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rprp_pkg::req_item_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rprp_pkg::rsp_item_type  rsp_data,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [11:0]             csr_wdata
);
   import rprp_pkg::*;

   localparam int ROW_W = $clog2(MAX_ROWS + 1);
   localparam int IDX_W = $clog2(MAX_ROWS);
   localparam int COL_W = $clog2(MAX_COLS + 1);
   localparam int CNT_W = (ROW_W > 11) ? ROW_W : 11;
   localparam int FIT_W = (COL_W > 13) ? COL_W : 13;
   localparam int END_W = CNT_W + 1;
   localparam int GH_W  = ROW_W + 8;
   localparam int GW_W  = COL_W + 8;
   localparam int RST_H = (INIT_HEIGHT_RST > MAX_ROWS) ? MAX_ROWS : INIT_HEIGHT_RST;
   localparam int RST_W = (INIT_WIDTH_RST > MAX_COLS) ? MAX_COLS : INIT_WIDTH_RST;

   // Configuration registers
   logic [10:0] cfg_ih_ff;
   logic [11:0] cfg_iw_ff;
   logic [6:0]  cfg_gp_ff;

   // Sequencer and datapath registers
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_row_ff, clr_row_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [11:0]        w_ff, w_in;
   logic [10:0]        h_ff, h_in;
   logic [IDX_W-1:0]   rd_row_ff, rd_row_in;
   logic               rd_more_ff, rd_more_in;
   logic               ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0]   ev_row_ff, ev_row_in;
   logic               first_ff, first_in;
   logic [11:0]        col_ff, col_in;
   logic [ROW_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   top_ff, top_in;
   logic [ROW_W-1:0]   qh_ff, qh_in;
   logic [COL_W-1:0]   qw_ff, qw_in;
   logic [ROW_W-1:0]   ch_ff, ch_in;
   logic [COL_W-1:0]   cw_ff, cw_in;
   logic [ROW_W-1:0]   wr_row_ff, wr_row_in;
   logic [END_W-1:0]   wr_end_ff, wr_end_in;
   logic [10:0]        res_x_ff, res_x_in;
   logic [9:0]         res_y_ff, res_y_in;
   logic               res_st_ff, res_st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;

   // Row fill memory
   logic [11:0]        mem [MAX_ROWS];
   logic [11:0]        mem_q_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   logic [11:0]        mem_wd;

   // Scan step results
   logic [11:0]        f_col;
   logic [ROW_W-1:0]   f_cnt;
   logic [IDX_W-1:0]   f_top;
   logic               f_brk;

   // Size and growth arithmetic
   logic [ROW_W-1:0]   load_h;
   logic [COL_W-1:0]   load_w;
   logic [ROW_W+DIV100_MUL_W-1:0] prod_h;
   logic [COL_W+DIV100_MUL_W-1:0] prod_w;
   logic [GH_W-1:0]    dh, nh;
   logic [GW_W-1:0]    dw, nw;
   logic               grow_ok;
   logic               spot_ok;
   logic               spot_fit;
   logic               wr_done;
   logic               out_free;

   // Capture configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ih_ff <= 11'(INIT_HEIGHT_RST);
         cfg_iw_ff <= 12'(INIT_WIDTH_RST);
         cfg_gp_ff <= 7'(GROWTH_RST);
      end else if (csr_we) begin
         case (csr_index)
            CSR_INIT_HEIGHT: cfg_ih_ff <= csr_wdata[10:0];
            CSR_INIT_WIDTH:  cfg_iw_ff <= csr_wdata;
            CSR_GROWTH:      cfg_gp_ff <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp the initial size into the canvas limits
   always_comb begin
      if (cfg_ih_ff == 11'd0) begin
         load_h = ROW_W'(1);
      end else if (32'(cfg_ih_ff) > MAX_ROWS) begin
         load_h = ROW_W'(MAX_ROWS);
      end else begin
         load_h = ROW_W'(cfg_ih_ff);
      end
      if (cfg_iw_ff == 12'd0) begin
         load_w = COL_W'(1);
      end else if (32'(cfg_iw_ff) > MAX_COLS) begin
         load_w = COL_W'(MAX_COLS);
      end else begin
         load_w = COL_W'(cfg_iw_ff);
      end
   end

   // One step of the run-counting scan on the row just read
   always_comb begin
      logic [11:0]      c_cur;
      logic [ROW_W-1:0] c_a;
      c_cur = first_ff ? mem_q_ff : col_ff;
      c_a   = (mem_q_ff < c_cur) ? '0 : count_ff;
      f_col = c_cur;
      f_cnt = c_a;
      f_top = top_ff;
      f_brk = 1'b0;
      if (CNT_W'(c_a) >= CNT_W'(h_ff)) begin
         if (mem_q_ff == c_cur) begin
            f_cnt = c_a + ROW_W'(1);
            f_top = ev_row_ff;
         end else begin
            f_brk = 1'b1;
         end
      end else begin
         f_top = ev_row_ff;
         if (mem_q_ff != c_cur) begin
            f_col = mem_q_ff;
         end else begin
            f_cnt = c_a + ROW_W'(1);
         end
      end
   end

   // Spot test, growth arithmetic and write range
   assign spot_ok  = CNT_W'(count_ff) >= CNT_W'(h_ff);
   assign spot_fit = (FIT_W'(col_ff) + FIT_W'(w_ff)) <= FIT_W'(cw_ff);
   assign prod_h   = (ROW_W+DIV100_MUL_W)'(ch_ff) * (ROW_W+DIV100_MUL_W)'(DIV100_MUL);
   assign prod_w   = (COL_W+DIV100_MUL_W)'(cw_ff) * (COL_W+DIV100_MUL_W)'(DIV100_MUL);
   assign dh       = GH_W'(qh_ff) * GH_W'(cfg_gp_ff);
   assign dw       = GW_W'(qw_ff) * GW_W'(cfg_gp_ff);
   assign nh       = GH_W'(ch_ff) + dh;
   assign nw       = GW_W'(cw_ff) + dw;
   assign grow_ok  = (dh != '0) && (dw != '0) && (nh <= GH_W'(MAX_ROWS))
                     && (nw <= GW_W'(MAX_COLS));
   assign wr_done  = (wr_row_ff == ROW_W'(MAX_ROWS)) || (END_W'(wr_row_ff) >= wr_end_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      clr_row_in   = clr_row_ff;
      clr_rsp_in   = clr_rsp_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      rd_row_in    = rd_row_ff;
      rd_more_in   = rd_more_ff;
      ev_vld_in    = 1'b0;
      ev_row_in    = ev_row_ff;
      first_in     = first_ff;
      col_in       = col_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      qh_in        = qh_ff;
      qw_in        = qw_ff;
      ch_in        = ch_ff;
      cw_in        = cw_ff;
      wr_row_in    = wr_row_ff;
      wr_end_in    = wr_end_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = clr_row_ff;
      mem_wd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               w_in = req_data.rect_width;
               h_in = req_data.rect_height;
               if (req_data.cmd == CMD_CLEAR) begin
                  clr_row_in = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = ST_CLEAR;
               end else begin
                  rd_row_in  = IDX_W'(ch_ff - ROW_W'(1));
                  rd_more_in = 1'b1;
                  first_in   = 1'b1;
                  count_in   = '0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_CLEAR: begin
            // Sweep zeros through the row memory
            mem_we     = 1'b1;
            mem_wa     = clr_row_ff;
            clr_row_in = clr_row_ff + IDX_W'(1);
            if (clr_row_ff == IDX_W'(MAX_ROWS - 1)) begin
               // A clear item reloads the size; the pass after reset keeps the reset size
               if (clr_rsp_ff) begin
                  ch_in = load_h;
                  cw_in = load_w;
               end
               res_x_in  = '0;
               res_y_in  = '0;
               res_st_in = STATUS_OK;
               state_in  = clr_rsp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_SCAN: begin
            // Issue the next read, bottom row first
            if (rd_more_ff) begin
               ev_vld_in  = 1'b1;
               ev_row_in  = rd_row_ff;
               rd_more_in = (rd_row_ff != '0);
               rd_row_in  = rd_row_ff - IDX_W'(1);
            end
            // Evaluate the row returned by the memory
            if (ev_vld_ff) begin
               first_in = 1'b0;
               if (!f_brk) begin
                  col_in   = f_col;
                  count_in = f_cnt;
                  top_in   = f_top;
               end else begin
                  col_in = f_col;
               end
               if (f_brk || ev_row_ff == '0) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (spot_ok && spot_fit) begin
               wr_row_in = ROW_W'(top_ff);
               wr_end_in = END_W'(top_ff) + END_W'(h_ff);
               state_in  = ST_WRITE;
            end else begin
               state_in = ST_GROW_DIV;
            end
         end
         ST_GROW_DIV: begin
            qh_in    = ROW_W'(prod_h >> DIV100_SHIFT);
            qw_in    = COL_W'(prod_w >> DIV100_SHIFT);
            state_in = ST_GROW_MUL;
         end
         ST_GROW_MUL: begin
            if (grow_ok) begin
               ch_in      = ROW_W'(nh);
               cw_in      = COL_W'(nw);
               rd_row_in  = IDX_W'(ROW_W'(nh) - ROW_W'(1));
               rd_more_in = 1'b1;
               first_in   = 1'b1;
               count_in   = '0;
               state_in   = ST_SCAN;
            end else begin
               res_x_in  = '0;
               res_y_in  = '0;
               res_st_in = STATUS_NO_ROOM;
               state_in  = ST_RESP;
            end
         end
         ST_WRITE: begin
            // Fill covered rows, one per cycle
            if (wr_done) begin
               res_x_in  = col_ff[10:0];
               res_y_in  = 10'(top_ff);
               res_st_in = STATUS_OK;
               state_in  = ST_RESP;
            end else begin
               mem_we    = 1'b1;
               mem_wa    = IDX_W'(wr_row_ff);
               mem_wd    = col_ff + w_ff;
               wr_row_in = wr_row_ff + ROW_W'(1);
            end
         end
         ST_RESP: begin
            // Hand the item to the output register once it is free
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.place_x       = res_x_ff;
               rsp_data_in.place_y       = res_y_ff;
               rsp_data_in.canvas_height = 11'(ch_ff);
               rsp_data_in.canvas_width  = 12'(cw_ff);
               rsp_data_in.status        = res_st_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_row_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rd_more_ff   <= 1'b0;
         ev_vld_ff    <= 1'b0;
         ch_ff        <= ROW_W'(RST_H);
         cw_ff        <= COL_W'(RST_W);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         clr_rsp_ff   <= clr_rsp_in;
         rd_more_ff   <= rd_more_in;
         ev_vld_ff    <= ev_vld_in;
         ch_ff        <= ch_in;
         cw_ff        <= cw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      h_ff        <= h_in;
      rd_row_ff   <= rd_row_in;
      ev_row_ff   <= ev_row_in;
      first_ff    <= first_in;
      col_ff      <= col_in;
      count_ff    <= count_in;
      top_ff      <= top_in;
      qh_ff       <= qh_in;
      qw_ff       <= qw_in;
      wr_row_ff   <= wr_row_in;
      wr_end_ff   <= wr_end_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Row memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[rd_row_ff];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Scan reads never race a row write
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !mem_we)
      else $error("row memory written during scan");

   // Canvas height stays inside its limits
   a_height_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE || state_ff == ST_IDLE) |->
         (ch_ff != '0) && (ch_ff <= ROW_W'(MAX_ROWS)))
      else $error("canvas height out of range");

   // Run count never exceeds the canvas height
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (count_ff <= ch_ff))
      else $error("run count beyond canvas height");

   // An accepted item leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
   import rprp_pkg::*;

   localparam int ROW_LIMIT      = 1024;
   localparam int COL_LIMIT      = 2048;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int HOLD_AFTER     = 30;
   localparam int HOLD_CYCLES    = 3000;

   // Track the row profile and canvas size; hold expected placements in order
   class packer_scoreboard;
      bit [11:0]    row_fill [ROW_LIMIT];
      int unsigned  canvas_rows;
      int unsigned  canvas_cols;
      int unsigned  init_rows;
      int unsigned  init_cols;
      int unsigned  growth_pct;
      rsp_item_type expected_q[$];
      int unsigned  error_count;

      function new();
         init_rows   = INIT_HEIGHT_RST;
         init_cols   = INIT_WIDTH_RST;
         growth_pct  = GROWTH_RST;
         error_count = 0;
         clear_canvas();
      endfunction

      // Empty every row and reload the clamped initial size
      function void clear_canvas();
         foreach (row_fill[r])
            row_fill[r] = '0;
         canvas_rows = (init_rows < 1) ? 1 : (init_rows > ROW_LIMIT) ? ROW_LIMIT : init_rows;
         canvas_cols = (init_cols < 1) ? 1 : (init_cols > COL_LIMIT) ? COL_LIMIT : init_cols;
      endfunction

      function void write_register(csr_index_type idx, logic [11:0] value);
         case (idx)
            CSR_INIT_HEIGHT: begin
               init_rows = value[10:0];
            end
            CSR_INIT_WIDTH: begin
               init_cols = value;
            end
            CSR_GROWTH: begin
               growth_pct = value[6:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Scan upward from the bottom row counting rows that share the candidate fill
      function bit find_spot(int unsigned h, output int unsigned sx, output int unsigned sy);
         int unsigned top;
         int unsigned col;
         int unsigned count;
         int unsigned r;
         int unsigned f;
         top   = canvas_rows - 1;
         col   = row_fill[top];
         count = 0;
         r     = canvas_rows;
         while (r > 0) begin
            r--;
            f = row_fill[r];
            if (f < col)
               count = 0;
            if (count >= h) begin
               if (f == col) begin
                  count++;
                  top = r;
                  continue;
               end
               break;
            end
            top = r;
            if (f != col)
               col = f;
            else
               count++;
         end
         sx = col;
         sy = top;
         return count >= h;
      endfunction

      // Grow both sizes by the percentage per hundred; refuse zero or oversize steps
      function bit grow_canvas();
         int unsigned dr;
         int unsigned dc;
         dr = (canvas_rows / 100) * growth_pct;
         dc = (canvas_cols / 100) * growth_pct;
         if (dr == 0 || dc == 0)
            return 1'b0;
         if (canvas_rows + dr > ROW_LIMIT || canvas_cols + dc > COL_LIMIT)
            return 1'b0;
         canvas_rows += dr;
         canvas_cols += dc;
         return 1'b1;
      endfunction

      // Work out the placement an accepted item should produce
      function void note_request(req_item_type item);
         rsp_item_type want;
         int unsigned  sx;
         int unsigned  sy;
         int unsigned  w;
         int unsigned  h;
         int unsigned  r;
         logic         status;
         w      = item.rect_width;
         h      = item.rect_height;
         sx     = 0;
         sy     = 0;
         status = STATUS_OK;
         if (item.cmd == CMD_CLEAR) begin
            clear_canvas();
         end else begin
            while (1) begin
               if (find_spot(h, sx, sy) && sx + w <= canvas_cols)
                  break;
               if (!grow_canvas()) begin
                  status = STATUS_NO_ROOM;
                  break;
               end
            end
            if (status == STATUS_OK) begin
               for (r = sy; r < sy + h && r < ROW_LIMIT; r++)
                  row_fill[r] = 12'(sx + w);
            end else begin
               sx = 0;
               sy = 0;
            end
         end
         want.place_x       = sx[10:0];
         want.place_y       = sy[9:0];
         want.canvas_height = canvas_rows[10:0];
         want.canvas_width  = canvas_cols[11:0];
         want.status        = status;
         expected_q = {expected_q, want};
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         error_count++;
      endtask

      // Compare a result against the oldest pending placement
      task check_response(rsp_item_type got);
         rsp_item_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("result with nothing pending");
            return;
         end
         want = expected_q.pop_front();
         if (got.place_x !== want.place_x)
            report_mismatch($sformatf("place_x got %0d expected %0d",
                                      got.place_x, want.place_x));
         if (got.place_y !== want.place_y)
            report_mismatch($sformatf("place_y got %0d expected %0d",
                                      got.place_y, want.place_y));
         if (got.canvas_height !== want.canvas_height)
            report_mismatch($sformatf("canvas_height got %0d expected %0d",
                                      got.canvas_height, want.canvas_height));
         if (got.canvas_width !== want.canvas_width)
            report_mismatch($sformatf("canvas_width got %0d expected %0d",
                                      got.canvas_width, want.canvas_width));
         if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      got.status, want.status));
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = CSR_INIT_HEIGHT;
   logic [11:0]  csr_wdata = '0;

   packer_scoreboard sb;
   int unsigned send_idle_pct = 37;
   int unsigned rcv_idle_pct = 84;
   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned random_sent = 0;
   int unsigned idle_cycles = 0;
   bit          hold_done = 1'b0;

   row_profile_rect_packer_core #(
      .MAX_ROWS(ROW_LIMIT),
      .MAX_COLS(COL_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Observe handshakes on both channels and watch for a hang
   always @(posedge clock) begin
      if (req_valid && !req_stall)
         sb.note_request(req_data);
      if (rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_data);
         results_seen++;
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Stall results at random; hold off once for a long stretch to back up the input
   initial begin
      forever begin
         @(posedge clock);
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= (rcv_idle_pct != 0) && ($urandom_range(99) < rcv_idle_pct);
      end
   end

   function automatic req_item_type make_item(logic cmd, int unsigned w, int unsigned h);
      req_item_type item;
      item.cmd         = cmd;
      item.rect_width  = w[11:0];
      item.rect_height = h[10:0];
      return item;
   endfunction

   // Offer one item after an optional gap and wait until it is taken
   task automatic send_item(input req_item_type item);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_place(int unsigned w, int unsigned h);
      send_item(make_item(CMD_PLACE, w, h));
   endtask

   task automatic send_clear();
      send_item(make_item(CMD_CLEAR, $urandom_range(4095), $urandom_range(2047)));
   endtask

   // Drop valid and wait until every item has returned its result
   task automatic drain();
      req_valid <= 1'b0;
      while (results_seen < items_sent)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [11:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(idx, value);
   endtask

   task automatic configure(int unsigned rows, int unsigned cols, int unsigned pct);
      write_csr(CSR_INIT_HEIGHT, rows[11:0]);
      write_csr(CSR_INIT_WIDTH, cols[11:0]);
      write_csr(CSR_GROWTH, pct[11:0]);
      csr_we <= 1'b0;
   endtask

   // Mostly modest rectangles, some clears, some at the full field range
   task automatic send_random_item();
      int unsigned pick;
      if (random_sent < 38) begin
         send_idle_pct = 37;
         rcv_idle_pct  = 84;
      end else if (random_sent < 76) begin
         send_idle_pct = 84;
         rcv_idle_pct  = 37;
      end else begin
         send_idle_pct = 0;
         rcv_idle_pct  = 0;
      end
      pick = $urandom_range(99);
      if (pick < 7)
         send_clear();
      else if (pick < 22)
         send_place($urandom_range(4095), $urandom_range(2047));
      else
         send_place($urandom_range(150), $urandom_range(60));
      random_sent++;
   endtask

   // Load a canvas setting, start from a clear canvas, then fill it at random
   task automatic run_random_phase(int unsigned rows, int unsigned cols, int unsigned pct,
                                   int unsigned count);
      drain();
      configure(rows, cols, pct);
      send_clear();
      repeat (count) send_random_item();
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Small canvas, halfway growth: zero size, full canvas, oversize items
      configure(100, 200, 50);
      send_clear();
      send_place(0, 0);
      send_place(1, 1);
      send_place(200, 100);
      send_place(4095, 1);
      send_place(1, 2047);
      send_place(2048, 1024);

      // Overlapping profile so covered rows get overwritten
      send_clear();
      send_place(50, 30);
      send_place(20, 10);
      send_place(100, 40);
      send_place(30, 60);
      send_place(4095, 2047);

      // Zero sizes clamp to one row and column; zero growth means no room
      drain();
      configure(0, 0, 0);
      send_clear();
      send_place(1, 1);
      send_place(1, 1);
      send_place(0, 0);

      // Oversize sizes clamp to the maximum canvas
      drain();
      configure(2047, 4095, 127);
      send_clear();
      send_place(2048, 1024);
      send_place(1, 1);

      run_random_phase(INIT_HEIGHT_RST, INIT_WIDTH_RST, GROWTH_RST, 20);
      run_random_phase(1024, 2048, 1, 19);
      run_random_phase(150, 300, 127, 19);
      run_random_phase(1, 1, 1, 16);
      run_random_phase(200, 400, 100, 20);
      run_random_phase(64, 2048, 50, 20);

      drain();
      repeat (16) @(posedge clock);
      if (sb.expected_q.size() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
      if (sb.error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/rprp_pkg.sv
design/row_profile_rect_packer_core.sv
tb/sv/testbench.sv
